// File: hw/rtl/usc_pkg.sv
// ----------------------------------------------------------------------------
// usc_pkg
// Shared types and constants for the utf-16 surrogate combiner.
// ----------------------------------------------------------------------------
package usc_pkg;

   localparam int UNIT_W  = 16;
   localparam int KEY_W   = 9;
   localparam int CP_W    = 21;
   localparam int HALF_W  = 10;
   localparam int PRE_W   = UNIT_W - HALF_W;

   // surrogate prefixes (top six bits of the code unit)
   localparam logic [PRE_W-1:0]  HIGH_PREFIX = 6'b110110;
   localparam logic [PRE_W-1:0]  LOW_PREFIX  = 6'b110111;
   localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h010000;
   localparam logic [UNIT_W-1:0] NONE_HELD   = 16'h0000;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
   localparam int MAX_PUSH   = 2;

   typedef enum logic [1:0] {
      PUSH_NONE = 2'd0,
      PUSH_ONE  = 2'd1,
      PUSH_TWO  = 2'd2
   } push_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [KEY_W-1:0] key_code_out;
      logic             last;
   } result_type;

   typedef struct packed {
      push_type          push;
      result_type        first;
      result_type        second;
      logic [UNIT_W-1:0] next_held;
   } decode_type;

   typedef struct packed {
      logic             space_ok;
      logic [CNT_W-1:0] count;
   } fifo_status_type;

endpackage

// File: hw/rtl/usc_req_if.sv
// ----------------------------------------------------------------------------
// usc_req_if
// Key event channel: valid/ready handshake with key event payload.
// ----------------------------------------------------------------------------
interface usc_req_if;
   import usc_pkg::*;

   logic              valid;
   logic              ready;
   logic              key_down;
   logic [UNIT_W-1:0] code_unit;
   logic [KEY_W-1:0]  key_code;

   modport source (output valid, output key_down, output code_unit, output key_code,
                   input ready);
   modport sink   (input valid, input key_down, input code_unit, input key_code,
                   output ready);
endinterface

// File: hw/rtl/usc_rsp_if.sv
// ----------------------------------------------------------------------------
// usc_rsp_if
// Code point channel: valid/ready handshake with decoded result payload.
// ----------------------------------------------------------------------------
interface usc_rsp_if;
   import usc_pkg::*;

   logic             valid;
   logic             ready;
   logic [CP_W-1:0]  code_point;
   logic [KEY_W-1:0] key_code_out;
   logic             last;

   modport source (output valid, output code_point, output key_code_out, output last,
                   input ready);
   modport sink   (input valid, input code_point, input key_code_out, input last,
                   output ready);
endinterface

// File: hw/rtl/usc_decode.sv
// ----------------------------------------------------------------------------
// usc_decode
// Classifies one code unit against the held high surrogate and forms the
// zero, one or two results plus the next held value.
// ----------------------------------------------------------------------------
module usc_decode (
   input  logic                      key_down,
   input  logic [usc_pkg::UNIT_W-1:0] code_unit,
   input  logic [usc_pkg::KEY_W-1:0]  key_code,
   input  logic [usc_pkg::UNIT_W-1:0] held,
   output usc_pkg::decode_type        dec
);
   import usc_pkg::*;

   logic            unit_high;
   logic            unit_low;
   logic            held_any;
   logic [CP_W-1:0] unit_cp;
   logic [CP_W-1:0] held_cp;
   logic [CP_W-1:0] pair_cp;

   assign unit_high = (code_unit[UNIT_W-1:HALF_W] == HIGH_PREFIX);
   assign unit_low  = (code_unit[UNIT_W-1:HALF_W] == LOW_PREFIX);
   assign held_any  = (held != NONE_HELD);
   assign unit_cp   = CP_W'(code_unit);
   assign held_cp   = CP_W'(held);
   assign pair_cp   = CP_W'({held[HALF_W-1:0], code_unit[HALF_W-1:0]}) + SUPP_BASE;

   always_comb begin
      dec.push      = PUSH_NONE;
      dec.first     = '{code_point: unit_cp, key_code_out: key_code, last: 1'b1};
      dec.second    = '{code_point: unit_cp, key_code_out: key_code, last: 1'b1};
      dec.next_held = held;
      if (key_down) begin
         if (!held_any) begin
            if (unit_high) begin
               dec.next_held = code_unit;
            end else begin
               dec.push = PUSH_ONE;
            end
         end else if (unit_low) begin
            dec.push             = PUSH_ONE;
            dec.first.code_point = pair_cp;
            dec.next_held        = NONE_HELD;
         end else if (unit_high) begin
            // flush the old surrogate, hold the new one
            dec.push             = PUSH_ONE;
            dec.first.code_point = held_cp;
            dec.next_held        = code_unit;
         end else begin
            dec.push             = PUSH_TWO;
            dec.first.code_point = held_cp;
            dec.first.last       = 1'b0;
            dec.next_held        = NONE_HELD;
         end
      end
   end

endmodule

// File: hw/rtl/usc_rsp_fifo.sv
// ----------------------------------------------------------------------------
// usc_rsp_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module usc_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  usc_pkg::push_type       push,
   input  usc_pkg::result_type     first,
   input  usc_pkg::result_type     second,
   output usc_pkg::fifo_status_type status,
   usc_rsp_if.source               rsp_chan
);
   import usc_pkg::*;

   result_type       mem [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [CNT_W-1:0] push_cnt;
   result_type       head;

   assign pop  = rsp_chan.valid && rsp_chan.ready;
   assign head = mem[rd_ptr_ff];

   always_comb begin
      case (push)
         PUSH_NONE: push_cnt = CNT_W'(0);
         PUSH_ONE:  push_cnt = CNT_W'(1);
         PUSH_TWO:  push_cnt = CNT_W'(2);
         default:   push_cnt = CNT_W'(0);
      endcase
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_cnt);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in  = count_ff + push_cnt - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push == PUSH_ONE || push == PUSH_TWO) begin
         mem[wr_ptr_ff] <= first;
      end
      if (push == PUSH_TWO) begin
         mem[wr_ptr_ff + PTR_W'(1)] <= second;
      end
   end

   assign status.count    = count_ff;
   assign status.space_ok = (count_ff <= CNT_W'(FIFO_DEPTH - MAX_PUSH));

   assign rsp_chan.valid        = (count_ff != '0);
   assign rsp_chan.code_point   = head.code_point;
   assign rsp_chan.key_code_out = head.key_code_out;
   assign rsp_chan.last         = head.last;

endmodule

// File: hw/rtl/utf16_surrogate_combiner.sv
// ----------------------------------------------------------------------------
// utf16_surrogate_combiner
// Turns a stream of UTF-16 key events into code points, pairing surrogates.
// ----------------------------------------------------------------------------
// one key event can be taken every cycle while the result queue has room; it is
// registered in the input register, decoded there and lands in a four-entry
// result queue, from whose head its first result is offered. an event that
// flushes a held surrogate ahead of its own unit gives two results, which
// leave the queue one after the other; the input stalls only when the queue
// holds more than two results. a high surrogate gives nothing until the next
// key-down event.
module utf16_surrogate_combiner (
   input  logic      clock,
   input  logic      reset,
   usc_req_if.sink   req_chan,
   usc_rsp_if.source rsp_chan
);
   import usc_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_key_down_ff;
   logic [UNIT_W-1:0] s1_unit_ff;
   logic [KEY_W-1:0]  s1_key_ff;
   logic [UNIT_W-1:0] held_ff, held_in;
   logic              s1_adv;
   logic              req_xfer;
   decode_type        dec;
   push_type          push;
   fifo_status_type   fifo_status;

   assign s1_adv         = s1_valid_ff && fifo_status.space_ok;
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_xfer || (s1_valid_ff && !s1_adv);
   assign held_in        = s1_adv ? dec.next_held : held_ff;
   assign push           = s1_adv ? dec.push : PUSH_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         held_ff     <= NONE_HELD;
      end else begin
         s1_valid_ff <= s1_valid_in;
         held_ff     <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_key_down_ff <= req_chan.key_down;
         s1_unit_ff     <= req_chan.code_unit;
         s1_key_ff      <= req_chan.key_code;
      end
   end

   usc_decode u_decode (
      .key_down  (s1_key_down_ff),
      .code_unit (s1_unit_ff),
      .key_code  (s1_key_ff),
      .held      (held_ff),
      .dec       (dec)
   );

   usc_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .first    (dec.first),
      .second   (dec.second),
      .status   (fifo_status),
      .rsp_chan (rsp_chan)
   );

   // held value is empty or a high surrogate
   a_held_is_high: assert property (@(posedge clock) disable iff (reset)
      held_ff == NONE_HELD || held_ff[UNIT_W-1:HALF_W] == HIGH_PREFIX)
      else $error("held value is not a high surrogate");

   // queue never overfills
   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= CNT_W'(FIFO_DEPTH))
      else $error("result queue overflow");

   // a stalled input register keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_adv |=> s1_valid_ff && $stable(s1_unit_ff) && $stable(held_ff))
      else $error("stalled item lost");

   // a queued result is visible on the port
   a_rsp_valid: assert property (@(posedge clock) disable iff (reset)
      push != PUSH_NONE |=> rsp_chan.valid)
      else $error("pushed result not presented");

endmodule
